### rtl/core/gauss_jordan_matrix_inverse_core_defines.svh
// Assertion macros for the matrix inverse core.
`ifndef GAUSS_JORDAN_MATRIX_INVERSE_CORE_DEFINES_SVH
`define GAUSS_JORDAN_MATRIX_INVERSE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define GJMI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define GJMI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GJMI_ASSERT(lbl, prop, msg)
`define GJMI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/core/gjmi_pkg.sv
// Shared types, constants and fixed-point helpers for the matrix inverse core.
package gjmi_pkg;

  localparam int DATA_W = 32;
  localparam int SIZE_W = 4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd4;

  typedef enum logic [1:0] {
    WSEL_KEEP = 2'd0,
    WSEL_EXT  = 2'd1,
    WSEL_ELIM = 2'd2
  } wsel_t;

  typedef struct packed {
    logic  adv;      // rotate the row ring one place
    wsel_t wsel;     // what enters the ring tail on a rotation
    logic  cap_f;    // capture the head as elimination factor
    logic  mul_en;   // register pivot * factor
    logic  init_id;  // set companion half to an identity row
    logic  f_we;     // load factor from row j's cell (row swap)
  } cell_ctrl_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    mag32 = x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic signed [31:0] sat32(input logic neg, input logic [63:0] mag);
    if (neg) begin
      if (mag >= 64'h8000_0000) sat32 = 32'sh8000_0000;
      else sat32 = -$signed(mag[31:0]);
    end else begin
      if (mag > 64'h7FFF_FFFF) sat32 = 32'sh7FFF_FFFF;
      else sat32 = $signed(mag[31:0]);
    end
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
    logic signed [32:0] r;
    r = {x[31], x} - {y[31], y};
    if (r[32] != r[31]) sub_sat = r[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else sub_sat = r[31:0];
  endfunction

endpackage

### rtl/core/gjmi_div.sv
// Restoring divider, one quotient bit a cycle: (|num| << F) / |den|, signed, saturated.
module gjmi_div #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);

  localparam int W  = 32 + FRACTION_BITS;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  shreg;
  logic [31:0]   rem;
  logic [31:0]   dvs;
  logic          neg;
  logic [CW-1:0] cnt;
  logic [32:0]   trial;
  logic          ge;

  assign trial = {rem, shreg[W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        shreg <= W'(gjmi_pkg::mag32(num)) << FRACTION_BITS;
        rem   <= '0;
        dvs   <= gjmi_pkg::mag32(den);
        neg   <= num[31] ^ den[31];
        cnt   <= CW'(W);
      end else if (cnt != '0) begin
        rem   <= ge ? 32'(trial - {1'b0, dvs}) : trial[31:0];
        shreg <= {shreg[W-2:0], ge};
        cnt   <= cnt - CW'(1);
        if (cnt == CW'(1)) done <= 1'b1;
      end
    end
  end

  assign quo = gjmi_pkg::sat32(neg, 64'(shreg));

endmodule

### rtl/core/gjmi_cell.sv
// One row cell: rotating ring of work and companion entries with its own multiply-subtract.
module gjmi_cell #(
  parameter int MAX_ORDER     = 8,
  parameter int FRACTION_BITS = 16,
  parameter int ROW           = 0
) (
  input  logic                         clk,
  input  gjmi_pkg::cell_ctrl_t         ctrl,
  input  logic signed [31:0]           ext_data,
  input  logic signed [31:0]           f_data,
  input  logic                         load_we,
  input  logic [$clog2(MAX_ORDER)-1:0] load_col,
  input  logic signed [31:0]           load_data,
  input  logic signed [31:0]           pivot,
  output logic signed [31:0]           head,
  output logic signed [31:0]           f
);

  localparam int L  = 2 * MAX_ORDER;
  localparam int LW = $clog2(L);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRACTION_BITS;

  // work entries at 0..MAX_ORDER-1, companion at MAX_ORDER..L-1; head is entry 0
  logic signed [31:0] ring [L];
  logic signed [31:0] prod;
  logic signed [31:0] tail_in;
  logic [63:0]        p_full;

  assign head   = ring[0];
  assign p_full = 64'(gjmi_pkg::mag32(pivot)) * 64'(gjmi_pkg::mag32(f));

  always_comb begin
    unique case (ctrl.wsel)
      gjmi_pkg::WSEL_EXT:  tail_in = ext_data;
      gjmi_pkg::WSEL_ELIM: tail_in = gjmi_pkg::sub_sat(ring[0], prod);
      default:             tail_in = ring[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      ring[LW'(load_col)] <= load_data;
    end else if (ctrl.init_id) begin
      for (int c = 0; c < MAX_ORDER; c++) begin
        ring[MAX_ORDER + c] <= (c == ROW) ? ONE : 32'sd0;
      end
    end else if (ctrl.adv) begin
      for (int k = 0; k < L - 1; k++) begin
        ring[k] <= ring[k + 1];
      end
      ring[L-1] <= tail_in;
    end
    if (ctrl.cap_f) f <= ring[0];
    else if (ctrl.f_we) f <= f_data;
    if (ctrl.mul_en) prod <= gjmi_pkg::sat32(pivot[31] ^ f[31], p_full >> FRACTION_BITS);
  end

endmodule

### rtl/core/gauss_jordan_matrix_inverse_core.sv
// Gauss-Jordan matrix inverse core: streams in an N x N Q16.16 matrix, streams out its inverse.
// Elements are taken one a cycle while s_tready is high (load state), row-major, and the
// inverse leaves row-major with tlast on its final element and tuser set on every element
// when a column had no nonzero pivot. A row of MAX_ORDER cells holds one matrix row each as a
// ring of 2*MAX_ORDER entries that all rotate in step. Per column: a pivot search over one
// full ring rotation, a row swap over one rotation when needed, a normalising rotation that
// waits on the serial divider for each nonzero pivot-row entry, and an elimination rotation
// with alternating multiply and subtract phases. Output takes one rotation per row. No input
// is taken from the last element until the final result has entered the output register.
module gauss_jordan_matrix_inverse_core #(
  parameter int MAX_ORDER     = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] matrix_element
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] inverse_element
  output logic        m_tlast,
  output logic        m_tuser,   // [0] singular
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data
);

  localparam int M  = MAX_ORDER;
  localparam int RW = $clog2(M);
  localparam int PW = $clog2(2 * M);
  localparam int NW = $clog2(M + 1);

  typedef enum logic [6:0] {
    ST_LOAD   = 7'b0000001,
    ST_INIT   = 7'b0000010,
    ST_SEARCH = 7'b0000100,
    ST_SWAP   = 7'b0001000,
    ST_NORM   = 7'b0010000,
    ST_ELIM   = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;

  state_t st;
  logic [gjmi_pkg::SIZE_W-1:0] matrix_size;
  logic [NW-1:0]   n;
  logic [RW-1:0]   ld_row, ld_col, j, piv, orow, pf_idx;
  logic [PW-1:0]   pos;
  logic            found, pf_found, singular, ph, div_run;
  logic signed [31:0] d;

  gjmi_pkg::cell_ctrl_t ctrl [M];
  logic signed [31:0] head [M];
  logic signed [31:0] fval [M];
  logic signed [31:0] ext  [M];
  logic [M-1:0]       load_we;

  logic div_start, div_done;
  logic signed [31:0] div_quo;
  logic last_pos, adv, emit, step, ld_last, col_last, rel;
  logic [PW-1:0] cpos;

  always_comb begin
    if (matrix_size == '0) n = NW'(1);
    else if (32'(matrix_size) > M) n = NW'(M);
    else n = NW'(matrix_size);
  end

  assign last_pos = pos == PW'(2 * M - 1);
  assign cpos     = pos - PW'(M);
  assign ld_last  = (ld_row == RW'(n - NW'(1))) && (ld_col == RW'(n - NW'(1)));
  assign col_last = j == RW'(n - NW'(1));
  assign s_tready = st == ST_LOAD;

  // first row at or below the diagonal with a nonzero entry in the head column
  always_comb begin
    pf_found = 1'b0;
    pf_idx   = '0;
    for (int i = 0; i < M; i++) begin
      if (!pf_found && i >= 32'(j) && i < 32'(n) && head[i] != 0) begin
        pf_found = 1'b1;
        pf_idx   = RW'(i);
      end
    end
  end

  always_comb begin
    rel  = (8'(pos) < 8'(n)) || (pos >= PW'(M) && 8'(cpos) < 8'(n));
    emit = (st == ST_OUT) && pos >= PW'(M) && 8'(cpos) < 8'(n);
    step = !emit || !m_tvalid || m_tready;
    div_start = 1'b0;
    adv = 1'b0;
    for (int i = 0; i < M; i++) begin
      ctrl[i] = '0;
      ext[i]  = head[i];
    end
    unique case (st)
      ST_INIT: begin
        for (int i = 0; i < M; i++) ctrl[i].init_id = 1'b1;
      end
      ST_SEARCH: begin
        adv = 1'b1;
        for (int i = 0; i < M; i++) ctrl[i].cap_f = pos == PW'(j);
      end
      ST_SWAP: begin
        adv = 1'b1;
        for (int i = 0; i < M; i++) begin
          if (RW'(i) == j) begin
            ctrl[i].wsel = gjmi_pkg::WSEL_EXT;
            ext[i] = head[piv];
          end else if (RW'(i) == piv) begin
            ctrl[i].wsel = gjmi_pkg::WSEL_EXT;
            ctrl[i].f_we = 1'b1;
            ext[i] = head[j];
          end
        end
      end
      ST_NORM: begin
        if (!rel || head[j] == 0) begin
          adv = 1'b1;
        end else if (!div_run) begin
          div_start = 1'b1;
        end else if (div_done) begin
          adv = 1'b1;
          for (int i = 0; i < M; i++) begin
            if (RW'(i) == j) begin
              ctrl[i].wsel = gjmi_pkg::WSEL_EXT;
              ext[i] = div_quo;
            end
          end
        end
      end
      ST_ELIM: begin
        adv = ph;
        for (int i = 0; i < M; i++) begin
          ctrl[i].mul_en = !ph;
          if (ph && RW'(i) != j && i < 32'(n)) ctrl[i].wsel = gjmi_pkg::WSEL_ELIM;
        end
      end
      ST_OUT: begin
        adv = step;
      end
      default: ;
    endcase
    for (int i = 0; i < M; i++) ctrl[i].adv = adv;
  end

  always_comb begin
    for (int i = 0; i < M; i++) load_we[i] = s_tvalid && s_tready && RW'(i) == ld_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= ST_LOAD;
      matrix_size <= gjmi_pkg::SIZE_RESET;
      ld_row      <= '0;
      ld_col      <= '0;
      pos         <= '0;
      j           <= '0;
      orow        <= '0;
      ph          <= 1'b0;
      div_run     <= 1'b0;
      found       <= 1'b0;
      singular    <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (emit && step) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (adv) pos <= last_pos ? '0 : pos + PW'(1);
      if (div_start) div_run <= 1'b1;
      else if (div_done) div_run <= 1'b0;
      if (cfg_we) begin
        matrix_size <= cfg_data;
        ld_row      <= '0;
        ld_col      <= '0;
      end
      unique case (st)
        ST_LOAD: begin
          if (s_tvalid && !cfg_we) begin
            if (ld_last) begin
              ld_row <= '0;
              ld_col <= '0;
              st     <= ST_INIT;
            end else if (ld_col == RW'(n - NW'(1))) begin
              ld_col <= '0;
              ld_row <= ld_row + RW'(1);
            end else begin
              ld_col <= ld_col + RW'(1);
            end
          end
        end
        ST_INIT: begin
          singular <= 1'b0;
          j        <= '0;
          pos      <= '0;
          st       <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (pos == PW'(j)) begin
            found <= pf_found;
            piv   <= pf_idx;
            d     <= head[pf_idx];
          end
          if (last_pos) begin
            if (!found) begin
              singular <= 1'b1;
              if (col_last) begin
                orow <= '0;
                st   <= ST_OUT;
              end else begin
                j <= j + RW'(1);
              end
            end else begin
              st <= (piv != j) ? ST_SWAP : ST_NORM;
            end
          end
        end
        ST_SWAP: begin
          if (last_pos) st <= ST_NORM;
        end
        ST_NORM: begin
          if (adv && last_pos) begin
            ph <= 1'b0;
            st <= ST_ELIM;
          end
        end
        ST_ELIM: begin
          ph <= !ph;
          if (ph && last_pos) begin
            if (col_last) begin
              orow <= '0;
              st   <= ST_OUT;
            end else begin
              j  <= j + RW'(1);
              st <= ST_SEARCH;
            end
          end
        end
        ST_OUT: begin
          if (adv && last_pos) begin
            if (orow == RW'(n - NW'(1))) st <= ST_LOAD;
            else orow <= orow + RW'(1);
          end
        end
        default: st <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit && step) begin
      m_tdata <= head[orow];
      m_tlast <= (orow == RW'(n - NW'(1))) && (8'(cpos) == 8'(n - NW'(1)));
      m_tuser <= singular;
    end
  end

  gjmi_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (head[j]),
    .den   (d),
    .done  (div_done),
    .quo   (div_quo)
  );

  for (genvar g = 0; g < M; g++) begin : g_cell
    gjmi_cell #(
      .MAX_ORDER     (MAX_ORDER),
      .FRACTION_BITS (FRACTION_BITS),
      .ROW           (g)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl[g]),
      .ext_data  (ext[g]),
      .f_data    (fval[j]),
      .load_we   (load_we[g]),
      .load_col  (ld_col),
      .load_data (s_tdata),
      .pivot     (head[j]),
      .head      (head[g]),
      .f         (fval[g])
    );
  end

`include "gauss_jordan_matrix_inverse_core_defines.svh"

  `GJMI_ASSERT(a_div_only_norm, div_done |-> st == ST_NORM, "divider finished outside normalise")
  `GJMI_ASSERT(a_swap_below, st == ST_SWAP |-> piv > j, "swap with a row not below the diagonal")
  `GJMI_ASSERT(a_emit_out, $rose(m_tvalid) |-> $past(st == ST_OUT), "result outside output phase")
  `GJMI_ASSERT_ALWAYS(a_rst_quiet, rst |=> !m_tvalid, "output valid after reset")

endmodule
